/* rtl/hts_pkg.sv */
package hts_pkg;

  // Event codes carried on the input side.
  typedef enum logic [2:0] {
    CMD_TICK      = 3'd0,
    CMD_ENABLE    = 3'd1,
    CMD_HYST_UP   = 3'd2,
    CMD_HYST_DOWN = 3'd3,
    CMD_VIEW      = 3'd4
  } cmd_e;

  localparam int unsigned CmdW     = 3;
  localparam int unsigned SampleW  = 10;
  localparam int unsigned HystW    = 7;
  localparam int unsigned TempW    = 18;
  localparam int unsigned SetW     = 17;

  // Compare width: holds setpoint + widest band and temperature, signed.
  localparam int unsigned CmpW     = 20;

  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 72;

  localparam int unsigned DefTicksPerSample = 500;
  localparam int unsigned DefHystMaxTenths  = 99;

  // temperature = 126 * t - 15400
  localparam logic [6:0]        TempGain   = 7'd126;
  localparam logic [TempW-1:0]  TempOffset = 18'd15400;

  // setpoint = 27500 + floor(p * 24990 / 511); the quotient is an exact
  // reciprocal multiply: ceil(24990 * 2^20 / 511), error term p * 196 < 2^20.
  localparam int unsigned       SetShift   = 20;
  localparam logic [25:0]       SetRecip   = 26'd51279676;
  localparam logic [SetW-1:0]   SetBase    = 17'd27500;

  // One tenth of a degree in milli-degrees.
  localparam logic [6:0]        BandStep   = 7'd100;

endpackage

/* rtl/hysteresis_thermostat_top.sv */
// On/off heater thermostat with adjustable hysteresis. Each input beat is one
// event, selected by s_axis_tuser: a 1 ms tick, an enable toggle, a
// hysteresis up or down press, or a view toggle; codes above the view toggle
// change nothing. Every TICKS_PER_SAMPLE-th tick latches the two ADC samples
// of that beat and converts them to milli-degrees (temperature 126*t-15400,
// setpoint 27500+floor(p*49980/1022)). Enabling forces the heater on,
// disabling forces it off, and after every event, while enabled, the heater
// turns off above setpoint+band and on below setpoint-band, band being the
// hysteresis in tenths times 100 milli-degrees. Every input beat gives
// exactly one output beat carrying the full state after that event, with
// m_axis_tuser high when the beat latched new samples. The block takes one
// beat per cycle while the output is not stalled; a taken beat passes the
// input register, then the result register. While a finished result
// waits downstream, the input register still takes one more beat and then
// holds s_axis_tready low until the waiting result leaves. The
// sample conversion, state update and band compare sit in one
// combinational pass between those two registers.
module hysteresis_thermostat_top
  import hts_pkg::*;
#(
  parameter int unsigned TICKS_PER_SAMPLE = DefTicksPerSample,
  parameter int unsigned HYST_MAX_TENTHS  = DefHystMaxTenths
) (
  input  logic                clk_i,
  input  logic                rst_ni,

  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [9:0] temp_sample, [19:10] setpoint_sample, [23:20] zero
  input  logic [InDataW-1:0]  s_axis_tdata,
  // [2:0] cmd
  input  logic [CmdW-1:0]     s_axis_tuser,

  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [0] heater_on, [1] enabled, [8:2] hyst_tenths, [9] view_mode,
  // [27:10] temp_milli, [44:28] setpoint_milli, [54:45] raw_temp,
  // [64:55] raw_setpoint, [71:65] zero
  output logic [OutDataW-1:0] m_axis_tdata,
  // [0] sampled
  output logic                m_axis_tuser
);

  localparam int unsigned TickW = (TICKS_PER_SAMPLE > 1) ? $clog2(TICKS_PER_SAMPLE) : 1;
  localparam logic [TickW-1:0] TickLast = TickW'(TICKS_PER_SAMPLE - 1);
  localparam logic [HystW-1:0] HystMax  = HystW'(HYST_MAX_TENTHS);

  // Input register.
  logic                      in_vld_q;
  logic [CmdW-1:0]           in_cmd_q;
  logic [SampleW-1:0]        in_temp_q, in_set_q;

  // Block state.
  logic                      enable_q, enable_d;
  logic                      heater_q, heater_d;
  logic [HystW-1:0]          hyst_q, hyst_d;
  logic                      view_q, view_d;
  logic [TickW-1:0]          tick_q, tick_d;
  logic signed [TempW-1:0]   temp_q, temp_d;
  logic [SetW-1:0]           set_q, set_d;
  logic [SampleW-1:0]        raw_temp_q, raw_temp_d;
  logic [SampleW-1:0]        raw_set_q, raw_set_d;
  logic                      sampled_d;

  // Result register.
  logic                      out_vld_q;
  logic [OutDataW-1:0]       out_data_q;
  logic                      out_user_q;

  logic                      advance;
  logic signed [TempW-1:0]   conv_temp;
  logic [SetW-1:0]           conv_set;
  logic [13:0]               band;
  logic signed [CmpW-1:0]    temp_ext, upper, lower;
  logic                      heat_evt;

  // Move the held beat into the result register whenever that slot frees up.
  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_cmd_q  <= s_axis_tuser;
      in_temp_q <= s_axis_tdata[SampleW-1:0];
      in_set_q  <= s_axis_tdata[2*SampleW-1:SampleW];
    end
  end

  hts_conv u_conv (
    .temp_sample_i     (in_temp_q),
    .setpoint_sample_i (in_set_q),
    .temp_milli_o      (conv_temp),
    .setpoint_milli_o  (conv_set)
  );

  // Apply the event to the state.
  always_comb begin
    enable_d   = enable_q;
    heat_evt   = heater_q;
    hyst_d     = hyst_q;
    view_d     = view_q;
    tick_d     = tick_q;
    temp_d     = temp_q;
    set_d      = set_q;
    raw_temp_d = raw_temp_q;
    raw_set_d  = raw_set_q;
    sampled_d  = 1'b0;
    case (cmd_e'(in_cmd_q))
      CMD_TICK: begin
        if (tick_q == TickLast) begin
          tick_d     = '0;
          temp_d     = conv_temp;
          set_d      = conv_set;
          raw_temp_d = in_temp_q;
          raw_set_d  = in_set_q;
          sampled_d  = 1'b1;
        end else begin
          tick_d = tick_q + TickW'(1);
        end
      end
      CMD_ENABLE: begin
        enable_d = !enable_q;
        heat_evt = !enable_q;
      end
      CMD_HYST_UP: begin
        if (hyst_q < HystMax) hyst_d = hyst_q + HystW'(1);
      end
      CMD_HYST_DOWN: begin
        if (hyst_q > HystW'(1)) hyst_d = hyst_q - HystW'(1);
      end
      CMD_VIEW: begin
        view_d = !view_q;
      end
      default: begin
      end
    endcase
  end

  // Band compare on the post-event values.
  assign band     = 14'(hyst_d) * 14'(BandStep);
  assign temp_ext = CmpW'(temp_d);
  assign upper    = signed'(CmpW'(set_d)) + signed'(CmpW'(band));
  assign lower    = signed'(CmpW'(set_d)) - signed'(CmpW'(band));

  always_comb begin
    heater_d = heat_evt;
    if (enable_d) begin
      if (temp_ext > upper) begin
        heater_d = 1'b0;
      end else if (temp_ext < lower) begin
        heater_d = 1'b1;
      end
    end
  end

  // Commit state as the beat advances.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q   <= 1'b0;
      heater_q   <= 1'b0;
      hyst_q     <= HystW'(1);
      view_q     <= 1'b0;
      tick_q     <= '0;
      temp_q     <= '0;
      set_q      <= '0;
      raw_temp_q <= '0;
      raw_set_q  <= '0;
    end else if (advance) begin
      enable_q   <= enable_d;
      heater_q   <= heater_d;
      hyst_q     <= hyst_d;
      view_q     <= view_d;
      tick_q     <= tick_d;
      temp_q     <= temp_d;
      set_q      <= set_d;
      raw_temp_q <= raw_temp_d;
      raw_set_q  <= raw_set_d;
    end
  end

  // Result register: load on advance, drop once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= {7'b0, raw_set_d, raw_temp_d, set_d, temp_d,
                     view_d, hyst_d, enable_d, heater_d};
      out_user_q <= sampled_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

`ifndef SYNTHESIS
  a_hyst_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hyst_q >= HystW'(1)) && (hyst_q <= HystMax))
    else $error("hysteresis out of range");

  a_tick_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_q <= TickLast)
    else $error("tick counter past sample period");

  a_heater_off : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !enable_q |-> !heater_q)
    else $error("heater on while disabled");

  a_hyst_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && (in_cmd_q != CMD_HYST_UP) && (in_cmd_q != CMD_HYST_DOWN))
    |=> $stable(hyst_q))
    else $error("hysteresis moved without a press");
`endif

endmodule

/* rtl/hts_conv.sv */
module hts_conv
  import hts_pkg::*;
(
  input  logic [SampleW-1:0]       temp_sample_i,
  input  logic [SampleW-1:0]       setpoint_sample_i,
  output logic signed [TempW-1:0]  temp_milli_o,
  output logic [SetW-1:0]          setpoint_milli_o
);

  logic [16:0]              temp_prod;
  logic [SampleW+25:0]      set_prod;
  logic [15:0]              set_quot;

  // Temperature: gain then offset, result always fits 18 bits signed.
  assign temp_prod    = 17'(temp_sample_i) * 17'(TempGain);
  assign temp_milli_o = signed'(TempW'(temp_prod)) - signed'(TempOffset);

  // Setpoint: divide by 1022 through the reciprocal, then add the base.
  assign set_prod         = (SampleW + 26)'(setpoint_sample_i) * (SampleW + 26)'(SetRecip);
  assign set_quot         = set_prod[SetShift +: 16];
  assign setpoint_milli_o = SetW'(set_quot) + SetBase;

endmodule

/* tb/hysteresis_thermostat_top_test.sv */
module hysteresis_thermostat_top_test;
  import hts_pkg::*;

  // Spare command codes above the view toggle.
  localparam logic [CmdW-1:0] CmdSpareLo = CmdW'(CMD_VIEW) + CmdW'(1);
  localparam logic [CmdW-1:0] CmdSpareHi = '1;

  // One input event as the sender queues it.
  typedef struct {
    logic [CmdW-1:0]    code;
    logic [SampleW-1:0] t_adc;
    logic [SampleW-1:0] p_adc;
  } event_t;

  // Thermostat status that one output beat must carry.
  typedef struct {
    logic              heater;
    logic              enabled;
    logic [HystW-1:0]  hyst;
    logic              view;
    int                temp_mc;
    int                setp_mc;
    logic [SampleW-1:0] raw_t;
    logic [SampleW-1:0] raw_p;
    logic              sampled;
  } status_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  // [9:0] temp_sample, [19:10] setpoint_sample, [23:20] zero
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  // [2:0] cmd
  logic [CmdW-1:0]     s_axis_tuser  = '0;

  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // [0] heater_on, [1] enabled, [8:2] hyst_tenths, [9] view_mode,
  // [27:10] temp_milli, [44:28] setpoint_milli, [54:45] raw_temp,
  // [64:55] raw_setpoint, [71:65] zero
  logic [OutDataW-1:0] m_axis_tdata;
  // [0] sampled
  logic                m_axis_tuser;

  hysteresis_thermostat_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // 20-unit period.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Events waiting to be offered, and status beats waiting to come out.
  event_t  event_q[$];
  status_t status_q[$];

  // Idle odds of the current phase, in percent.
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  // Predicted thermostat state, advanced once per accepted input beat.
  logic               th_enabled = 1'b0;
  logic               th_heater  = 1'b0;
  int                 th_hyst    = 1;
  logic               th_view    = 1'b0;
  int                 th_ticks   = 0;
  int                 th_temp    = 0;
  int                 th_setp    = 0;
  logic [SampleW-1:0] th_raw_t   = '0;
  logic [SampleW-1:0] th_raw_p   = '0;

  // Stimulus-side shadow of the tick counter and hysteresis, used only to
  // spot the sampling tick and to aim its samples at the band.
  int gen_ticks = 0;
  int gen_hyst  = 1;

  int fail_count   = 0;
  int beats_seen   = 0;
  int latch_count  = 0;
  int hyst_peak    = 0;
  int heater_beats = 0;

  // Apply one event to the predicted state and queue the status it yields.
  task automatic thermostat_step(input logic [CmdW-1:0] code,
                                 input logic [SampleW-1:0] t_adc,
                                 input logic [SampleW-1:0] p_adc);
    status_t s;
    int      band;
    s.sampled = 1'b0;
    case (cmd_e'(code))
      CMD_TICK: begin
        th_ticks++;
        if (th_ticks >= DefTicksPerSample) begin
          th_ticks  = 0;
          th_raw_t  = t_adc;
          th_raw_p  = p_adc;
          th_temp   = int'(t_adc) * 126 - 15400;
          th_setp   = 27500 + (int'(p_adc) * 49980) / 1022;
          s.sampled = 1'b1;
        end
      end
      CMD_ENABLE: begin
        // enabling forces the heater on, disabling forces it off
        th_enabled = !th_enabled;
        th_heater  = th_enabled;
      end
      CMD_HYST_UP: begin
        if (th_hyst < DefHystMaxTenths) th_hyst++;
      end
      CMD_HYST_DOWN: begin
        if (th_hyst > 1) th_hyst--;
      end
      CMD_VIEW: begin
        th_view = !th_view;
      end
      default: begin
        // unused codes leave the state alone
      end
    endcase
    // Band compare on the post-event state; inside the band hold the heater.
    if (th_enabled) begin
      band = th_hyst * 100;
      if (th_temp > th_setp + band) th_heater = 1'b0;
      else if (th_temp < th_setp - band) th_heater = 1'b1;
    end
    s.heater  = th_heater;
    s.enabled = th_enabled;
    s.hyst    = th_hyst[HystW-1:0];
    s.view    = th_view;
    s.temp_mc = th_temp;
    s.setp_mc = th_setp;
    s.raw_t   = th_raw_t;
    s.raw_p   = th_raw_p;
    status_q.push_back(s);
  endtask

  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Check one output beat against the oldest predicted status.
  task automatic check_beat();
    status_t w;
    int      got_temp;
    if (status_q.size() == 0) begin
      $error("output beat with no prediction pending");
      fail_count++;
    end else begin
      w        = status_q.pop_front();
      got_temp = $signed(m_axis_tdata[27:10]);
      compare_field("heater_on",      w.heater,      m_axis_tdata[0]);
      compare_field("enabled",        w.enabled,     m_axis_tdata[1]);
      compare_field("hyst_tenths",    w.hyst,        m_axis_tdata[8:2]);
      compare_field("view_mode",      w.view,        m_axis_tdata[9]);
      compare_field("temp_milli",     w.temp_mc,     got_temp);
      compare_field("setpoint_milli", w.setp_mc,     int'(m_axis_tdata[44:28]));
      compare_field("raw_temp",       w.raw_t,       m_axis_tdata[54:45]);
      compare_field("raw_setpoint",   w.raw_p,       m_axis_tdata[64:55]);
      compare_field("sampled",        w.sampled,     m_axis_tuser);
      beats_seen++;
      if (w.sampled) latch_count++;
      if (w.heater) heater_beats++;
      if (w.hyst > hyst_peak) hyst_peak = w.hyst;
    end
  endtask

  // Sender: predict on each accepted beat, then offer the next queued event
  // unless this cycle idles. Hold the beat while the block refuses it.
  always @(posedge clk_i) begin : drive_proc
    event_t next_ev;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        thermostat_step(s_axis_tuser, s_axis_tdata[9:0], s_axis_tdata[19:10]);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (event_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_ev = event_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= next_ev.code;
          s_axis_tdata  <= {{(InDataW - 2 * SampleW){1'b0}}, next_ev.p_adc, next_ev.t_adc};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each taken beat, then pick this cycle's ready at random.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) check_beat();
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Queue one event and advance the stimulus-side shadow.
  task automatic add_event(input logic [CmdW-1:0] code,
                           input logic [SampleW-1:0] t_adc,
                           input logic [SampleW-1:0] p_adc);
    event_t e;
    e.code  = code;
    e.t_adc = t_adc;
    e.p_adc = p_adc;
    event_q.push_back(e);
    case (cmd_e'(code))
      CMD_TICK:      gen_ticks = (gen_ticks + 1) % DefTicksPerSample;
      CMD_HYST_UP:   if (gen_hyst < DefHystMaxTenths) gen_hyst++;
      CMD_HYST_DOWN: if (gen_hyst > 1) gen_hyst--;
      default: ;
    endcase
  endtask

  function automatic logic [SampleW-1:0] any_adc();
    return SampleW'($urandom_range(0, 1023));
  endfunction

  // One random press: enable, hysteresis step, view toggle or a spare code.
  task automatic add_press();
    int kind;
    kind = $urandom_range(0, 9);
    if (kind <= 2) begin
      add_event(CMD_ENABLE, any_adc(), any_adc());
    end else if (kind <= 5) begin
      add_event(CMD_HYST_UP, any_adc(), any_adc());
    end else if (kind <= 7) begin
      add_event(CMD_HYST_DOWN, any_adc(), any_adc());
    end else if (kind == 8) begin
      add_event(CMD_VIEW, any_adc(), any_adc());
    end else begin
      add_event(CmdW'($urandom_range(CmdSpareLo, CmdSpareHi)), any_adc(), any_adc());
    end
  endtask

  // Sampling tick: aim the temperature near the band around the setpoint.
  task automatic add_sample_tick();
    int                 band;
    int                 off;
    int                 setp_v;
    int                 t_pick;
    logic [SampleW-1:0] p_pick;
    p_pick = any_adc();
    setp_v = 27500 + (int'(p_pick) * 49980) / 1022;
    band   = gen_hyst * 100;
    off    = int'($urandom_range(0, 2 * band + 800)) - (band + 400);
    t_pick = (setp_v + off + 15400) / 126;
    if (t_pick > 1023) t_pick = 1023;
    add_event(CMD_TICK, t_pick[SampleW-1:0], p_pick);
  endtask

  // Plain tick, or the aimed one when it is the sampling tick.
  task automatic add_tick();
    if (gen_ticks == DefTicksPerSample - 1) add_sample_tick();
    else add_event(CMD_TICK, any_adc(), any_adc());
  endtask

  // Queue ticks and presses shuffled together.
  task automatic add_mix(input int n_ticks, input int n_press);
    int ticks_left;
    int press_left;
    ticks_left = n_ticks;
    press_left = n_press;
    while (ticks_left + press_left > 0) begin
      if ($urandom_range(1, ticks_left + press_left) <= ticks_left) begin
        add_tick();
        ticks_left--;
      end else begin
        add_press();
        press_left--;
      end
    end
  endtask

  // Block until every queued event has gone in and every status came out.
  task automatic wait_drained();
    while (event_q.size() != 0 || s_axis_tvalid || status_q.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  task automatic run_phase(input int unsigned send_pct, input int unsigned recv_pct,
                           input int n_ticks, input int n_press);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    add_mix(n_ticks, n_press);
    wait_drained();
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed opening: view toggles, unused codes, hysteresis floor,
    // enable on/off/on before any sample, and ticks whose samples must
    // not latch.
    add_event(CMD_VIEW,      10'd0,    10'd0);
    add_event(CMD_VIEW,      10'd1023, 10'd1023);
    add_event(CmdSpareLo,    10'd1023, 10'd0);
    add_event(CmdSpareHi,    10'd0,    10'd1023);
    add_event(CmdSpareHi,    10'd1023, 10'd1023);
    add_event(CMD_HYST_DOWN, 10'd0,    10'd0);
    add_event(CMD_HYST_UP,   10'd0,    10'd0);
    add_event(CMD_HYST_UP,   10'd0,    10'd0);
    add_event(CMD_HYST_DOWN, 10'd0,    10'd0);
    add_event(CMD_ENABLE,    10'd0,    10'd0);
    add_event(CMD_TICK,      10'd1023, 10'd1023);
    add_event(CMD_ENABLE,    10'd0,    10'd0);
    add_event(CMD_ENABLE,    10'd0,    10'd0);
    add_event(CMD_TICK,      10'd0,    10'd0);
    add_event(CMD_HYST_DOWN, 10'd0,    10'd0);
    add_event(CMD_HYST_DOWN, 10'd0,    10'd0);
    add_event(CMD_VIEW,      10'd0,    10'd0);
    add_event(CmdSpareHi,    10'd0,    10'd0);

    // Phases: steady flow, sender gaps, receiver backpressure, both. The
    // single sampling tick lands in the last phase, followed by presses
    // that move the band and toggle the enable around the new samples.
    run_phase(0, 0, 110, 3);
    run_phase(70, 0, 110, 3);
    run_phase(0, 70, 110, 3);
    send_idle_pct  = 24;
    recv_stall_pct = 24;
    add_mix(DefTicksPerSample - 2 - 3 * 110, 3);
    add_mix(2, 12);
    wait_drained();

    // Let the two-stage pipe settle and catch any stray beat.
    repeat (8) @(posedge clk_i);

    $display("Summary: %0d status beats compared across four flow phases, %0d sample latches,",
             beats_seen, latch_count);
    $display("         hysteresis peaked at %0d tenths, heater on in %0d beats",
             hyst_peak, heater_beats);
    if (fail_count == 0) begin
      $display("hysteresis_thermostat_top_test: clean");
    end else begin
      $display("hysteresis_thermostat_top_test: errors");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("timeout with %0d events and %0d statuses outstanding",
             event_q.size(), status_q.size());
    $display("hysteresis_thermostat_top_test: errors");
    $finish;
  end

endmodule
